[design/hmt_pkg.sv]
// Shared types, constants and helper functions of the histogram mode threshold block.
package hmt_pkg;

  localparam int BIN_COUNT  = 256;
  localparam int COUNT_BITS = 20;
  localparam int BIN_BITS   = $clog2(BIN_COUNT);
  localparam int WIDE_BITS  = (BIN_BITS > 8) ? BIN_BITS : 8;
  localparam int APB_ADDR_W = 3;

  typedef logic [BIN_BITS-1:0]   bin_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam bin_idx_t LAST_BIN  = bin_idx_t'(BIN_COUNT - 1);
  localparam count_t   COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [7:0] GAP_RESET = 8'd50;

  // Register index taken from the word address
  localparam logic REG_PEAK_GAP = 1'b0;

  typedef struct packed {
    logic [7:0] gray;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] threshold;
    logic [7:0] first_peak;
    logic [7:0] second_peak;
  } out_item_t;

  typedef enum logic [1:0] {
    CMP_LE = 2'd0,
    CMP_LT = 2'd1,
    CMP_GT = 2'd2
  } cmp_op_t;

  typedef struct packed {
    logic    vld;
    logic    first;
    cmp_op_t op;
  } scan_ctl_t;

  // Gray level to bin; levels past the last bin land in the last bin
  function automatic bin_idx_t bin_of(input logic [7:0] gray);
    logic [WIDE_BITS-1:0] g;
    g = WIDE_BITS'(gray);
    if (g > WIDE_BITS'(LAST_BIN)) begin
      return LAST_BIN;
    end
    return BIN_BITS'(g);
  endfunction

  // Start of the second peak search, clamped to the last bin
  function automatic bin_idx_t gap_start(input bin_idx_t p1, input logic [7:0] gap);
    logic [WIDE_BITS:0] s;
    s = (WIDE_BITS+1)'(p1) + (WIDE_BITS+1)'(gap);
    if (s > (WIDE_BITS+1)'(LAST_BIN)) begin
      return LAST_BIN;
    end
    return BIN_BITS'(s);
  endfunction

  function automatic logic [7:0] idx_to_out(input bin_idx_t idx);
    return 8'(idx);
  endfunction

endpackage

[design/hmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/hmt_scan.sv]
// Shared compare unit: keeps the best bin seen so far in a pass and updates it per bin.
module hmt_scan (
  input  logic               clk,
  input  hmt_pkg::scan_ctl_t ctl,
  input  hmt_pkg::count_t    cur_cnt,
  input  hmt_pkg::bin_idx_t  cur_idx,
  output hmt_pkg::bin_idx_t  best_idx
);
  import hmt_pkg::*;

  count_t   best_cnt_r;
  bin_idx_t best_idx_r;
  logic     lt;
  logic     eq;
  logic     take;

  assign lt = best_cnt_r < cur_cnt;
  assign eq = best_cnt_r == cur_cnt;

  always_comb begin
    case (ctl.op)
      CMP_LE:  take = lt | eq;
      CMP_LT:  take = lt;
      CMP_GT:  take = ~lt & ~eq;
      default: take = 1'b0;
    endcase
  end

  // First bin of a pass always loads the candidate
  always_ff @(posedge clk) begin
    if (ctl.vld && (ctl.first || take)) begin
      best_cnt_r <= cur_cnt;
      best_idx_r <= cur_idx;
    end
  end

  assign best_idx = best_idx_r;

endmodule

[design/histogram_mode_threshold_unit.sv]
// Top level: pixel histogram with end-of-frame mode-method threshold scan.
//
// Usage: gray pixels arrive on in_data (gray, last) with in_valid/in_stall; a
// transfer happens when in_valid is high and in_stall is low. Each pixel is
// counted into a 256-bin histogram held in one RAM; a bin saturates at its
// maximum. Each pixel is read from the RAM, then written back with the bumped
// count, so in_stall is high for one cycle after each transfer.
// On a pixel with last set, three passes over the RAM follow, one bin per
// cycle through a single shared compare unit: first peak over all bins, second
// peak from first peak + peak_gap to the end, valley from first to second peak.
// From the last pixel until the result is loaded, in_stall stays high. The
// result (threshold, first_peak, second_peak) sits in an output register until
// out_stall is low; a scan that finishes while it is still held waits for it.
// Loading the result clears the histogram at once through its per-bin valid
// bits. Reset clears the histogram, sets peak_gap to 50 and drops out_valid.
// peak_gap is written through the APB port at byte address 0.
module histogram_mode_threshold_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  hmt_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output hmt_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hmt_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import hmt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_P1   = 8'b0000_0100,
    S_P2S  = 8'b0000_1000,
    S_P2   = 8'b0001_0000,
    S_P3S  = 8'b0010_0000,
    S_P3   = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t    state_r, state_nxt;
  logic [7:0] gap_r;

  bin_idx_t  iss_idx_r, iss_idx_nxt;
  bin_idx_t  iss_end_r, iss_end_nxt;
  logic      iss_act_r, iss_act_nxt;
  logic      iss_first_r, iss_first_nxt;

  logic      pend_vld_r;
  bin_idx_t  pend_idx_r;
  logic      pend_first_r;
  logic      pend_last_r;

  bin_idx_t  pix_idx_r, pix_idx_nxt;
  logic      pix_last_r, pix_last_nxt;
  bin_idx_t  p1_r, p1_nxt;
  bin_idx_t  p2_r, p2_nxt;

  logic      out_valid_r;
  out_item_t out_r, out_nxt;
  logic      out_load;

  logic [BIN_COUNT-1:0] vld_r, vld_nxt;
  logic      vld_q_r;

  logic      in_acc;
  logic      scan_st;
  logic      issue;
  logic      pass_done;
  logic      cfg_wr;
  bin_idx_t  rd_addr;
  count_t    ram_q;
  count_t    cur_cnt;
  count_t    wr_cnt;
  logic      ram_we;
  bin_idx_t  best_idx;
  scan_ctl_t scan_ctl;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_PEAK_GAP) ? {24'd0, gap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_PEAK_GAP)) begin
      gap_r <= pwdata[7:0];
    end
  end

  // ---------------- histogram storage ----------------
  assign rd_addr = (state_r == S_IDLE) ? bin_of(in_data.gray) : iss_idx_r;
  assign ram_we  = (state_r == S_RD);
  assign cur_cnt = vld_q_r ? ram_q : '0;
  assign wr_cnt  = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + count_t'(1);

  hmt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pix_idx_r),
    .wdata (wr_cnt),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // A bin not written since the last clear reads as zero
  always_comb begin
    vld_nxt = vld_r;
    if (ram_we) begin
      vld_nxt[pix_idx_r] = 1'b1;
    end
    if (out_load) begin
      vld_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    vld_q_r <= vld_r[rd_addr];
  end

  // ---------------- shared compare unit ----------------
  always_comb begin
    scan_ctl.vld   = pend_vld_r;
    scan_ctl.first = pend_first_r;
    case (state_r)
      S_P2:    scan_ctl.op = CMP_LT;
      S_P3:    scan_ctl.op = CMP_GT;
      default: scan_ctl.op = CMP_LE;
    endcase
  end

  hmt_scan u_scan (
    .clk      (clk),
    .ctl      (scan_ctl),
    .cur_cnt  (cur_cnt),
    .cur_idx  (pend_idx_r),
    .best_idx (best_idx)
  );

  // ---------------- sequencer ----------------
  assign scan_st   = (state_r == S_P1) || (state_r == S_P2) || (state_r == S_P3);
  assign issue     = scan_st & iss_act_r;
  assign pass_done = pend_vld_r & pend_last_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    iss_idx_nxt   = iss_idx_r;
    iss_end_nxt   = iss_end_r;
    iss_act_nxt   = iss_act_r;
    iss_first_nxt = iss_first_r;
    pix_idx_nxt   = pix_idx_r;
    pix_last_nxt  = pix_last_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    out_nxt       = out_r;

    // advance the read address one bin a cycle while a pass is running
    if (issue) begin
      iss_idx_nxt   = iss_idx_r + bin_idx_t'(1);
      iss_first_nxt = 1'b0;
      iss_act_nxt   = (iss_idx_r != iss_end_r);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pix_idx_nxt  = bin_of(in_data.gray);
          pix_last_nxt = in_data.last;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        if (pix_last_r) begin
          iss_idx_nxt   = '0;
          iss_end_nxt   = LAST_BIN;
          iss_act_nxt   = 1'b1;
          iss_first_nxt = 1'b1;
          state_nxt     = S_P1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_P1: begin
        if (pass_done) begin
          state_nxt = S_P2S;
        end
      end
      S_P2S: begin
        p1_nxt        = best_idx;
        iss_idx_nxt   = gap_start(best_idx, gap_r);
        iss_end_nxt   = LAST_BIN;
        iss_act_nxt   = 1'b1;
        iss_first_nxt = 1'b1;
        state_nxt     = S_P2;
      end
      S_P2: begin
        if (pass_done) begin
          state_nxt = S_P3S;
        end
      end
      S_P3S: begin
        p2_nxt        = best_idx;
        iss_idx_nxt   = p1_r;
        iss_end_nxt   = best_idx;
        iss_act_nxt   = 1'b1;
        iss_first_nxt = 1'b1;
        state_nxt     = S_P3;
      end
      S_P3: begin
        if (pass_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_nxt.threshold   = idx_to_out(best_idx);
          out_nxt.first_peak  = idx_to_out(p1_r);
          out_nxt.second_peak = idx_to_out(p2_r);
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_act_r   <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      iss_act_r  <= iss_act_nxt;
      pend_vld_r <= issue;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_idx_r    <= iss_idx_nxt;
    iss_end_r    <= iss_end_nxt;
    iss_first_r  <= iss_first_nxt;
    pend_idx_r   <= iss_idx_r;
    pend_first_r <= iss_first_r;
    pend_last_r  <= (iss_idx_r == iss_end_r);
    pix_idx_r    <= pix_idx_nxt;
    pix_last_r   <= pix_last_nxt;
    p1_r         <= p1_nxt;
    p2_r         <= p2_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- assertions ----------------
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised without a finished scan");

  a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> vld_r == '0)
    else $error("histogram not cleared after result load");

  a_valley_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P3) |-> p1_r <= p2_r)
    else $error("valley pass runs with second peak before first peak");

  a_second_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P2) && iss_act_r |-> iss_idx_r >= p1_r)
    else $error("second peak search reads below first peak");

endmodule
